// ===== rtl/core/ckm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckm_pkg: shared types and constants for the circular k-means block
// Holds field widths, controller states, the command and status structs
// between controller and datapath, and the quarter-wave sine function.
// ----------------------------------------------------------------------------
package ckm_pkg;

	localparam int MaxClusters = 8;
	localparam int MaxSamples = 1024;
	localparam int IdxW = 3;
	localparam int AngW = 15;
	localparam int SumW = 25;
	localparam int CntW = 11;
	localparam int PassW = 11;
	localparam int TrigW = 16;
	localparam int DistW = 34;
	localparam int QuarterTurn = 5760;
	localparam int FullTurn = 23040;
	localparam int DivW = 26;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMPLE_TRIG,
		ST_SCAN,
		ST_ACCUM,
		ST_DIVIDE,
		ST_EMIT
	} ckm_state_t;

	typedef struct packed {
		logic             load_mean;
		logic             sample_trig;
		logic             scan_start;
		logic             scan_step;
		logic             accumulate;
		logic             div_start;
		logic             emit_clear;
		logic [IdxW-1:0]  idx;
	} ckm_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic pass_full;
	} ckm_status_t;

	// Quarter-wave sine, Q1.14, f in 0..5760 in 1/64 degree.
	function automatic logic [TrigW-1:0] quarter_sine(input logic [12:0] f);
		logic [63:0] r, r2, t, s;
		begin
			r = 64'(f) * 64'd292818;
			r2 = (r * r) >> 30;
			t = (64'd1 << 30) - r2 / 64'd72;
			t = (64'd1 << 30) - ((r2 * t) >> 30) / 64'd42;
			t = (64'd1 << 30) - ((r2 * t) >> 30) / 64'd20;
			t = (64'd1 << 30) - ((r2 * t) >> 30) / 64'd6;
			s = (r * t) >> 30;
			quarter_sine = TrigW'((s + 64'd32768) >> 16);
		end
	endfunction

endpackage

// ===== rtl/core/circular_kmeans_iteration.sv =====
// ----------------------------------------------------------------------------
// circular_kmeans_iteration: one k-means pass over angles on the circle
//
// Input words arrive on a valid/ready channel. A load word (kind 0) writes
// one cluster mean. A sample word (kind 1) goes through the sine/cosine
// lookup, then each active mean in turn goes through the same shared trig
// unit and is compared, and the sample is accumulated into the nearest one.
// A sample marked last then runs a restoring divider for each cluster with
// members and sends one result word per active cluster on the output channel,
// which is held in an output register; a stall on out_ready simply holds
// the sequencer in its emit state until the word is taken.
// Reset clears all means, sums and tallies and sets cluster_count to 2.
// cluster_count must be written through cfg_we/cfg_data only while the block
// idles; the user keeps to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module circular_kmeans_iteration import ckm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [IdxW-1:0]        cluster_slot,
	input  logic signed [AngW-1:0] angle,
	input  logic                   last_sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [IdxW-1:0]        cluster_index,
	output logic signed [AngW-1:0] new_mean,
	output logic [CntW-1:0]        member_count,
	output logic                   last_result
);

	logic [3:0] count_q;
	logic [IdxW:0] n_active;
	ckm_cmd_t cmd;
	ckm_status_t status;
	logic out_load, out_free;
	logic signed [AngW-1:0] res_mean;
	logic [CntW-1:0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= 4'd2;
		else if (cfg_we) count_q <= cfg_data;
	end

	// Zero counts as one cluster; anything above the storage saturates.
	always_comb begin
		if (count_q == 0) n_active = (IdxW+1)'(1);
		else if (count_q > 4'(MaxClusters)) n_active = (IdxW+1)'(MaxClusters);
		else n_active = count_q;
	end

	ckm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_kind(kind), .in_last(last_sample), .n_active(n_active),
		.status(status), .cmd(cmd), .out_load(out_load), .out_free(out_free)
	);

	ckm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_slot(cluster_slot),
		.in_angle(angle), .n_active(n_active), .status(status),
		.res_mean(res_mean), .res_count(res_count)
	);

	// Output register: free when empty or being taken this cycle.
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cluster_index <= cmd.idx;
			new_mean <= res_mean;
			member_count <= res_count;
			last_result <= ({1'b0, cmd.idx} == n_active - 1'b1);
		end
	end

endmodule

// ===== rtl/core/ckm_trig.sv =====
// ----------------------------------------------------------------------------
// ckm_trig: sine and cosine lookup
// Reduces an angle mod a full turn and folds it into a quarter-wave table.
// Wrap and fold are registered, then the table read is registered as well.
// ----------------------------------------------------------------------------
module ckm_trig import ckm_pkg::*; (
	input  logic                    clk,
	input  logic signed [AngW-1:0]  angle,
	output logic signed [TrigW-1:0] sin_val,
	output logic signed [TrigW-1:0] cos_val
);

	logic [14:0] wrapped;
	logic [14:0] cwrap;
	logic [12:0] sf_s1, cf_s1;
	logic        sn_s1, cn_s1;
	logic [12:0] sf, cf;
	logic        sn, cn;
	logic [TrigW-1:0] sine_rom [QuarterTurn+1];
	logic [TrigW-1:0] smag_s2, cmag_s2;
	logic             sn_s2, cn_s2;

	// The quarter-wave table is filled once with constant values.
	initial begin
		for (int i = 0; i <= QuarterTurn; i++) sine_rom[i] = quarter_sine(13'(i));
	end

	// angle lies in -16384..16383, so one add or subtract lands in 0..23039
	always_comb begin
		if (angle < 0) begin
			wrapped = 15'(int'(angle) + FullTurn);
		end else if (int'(angle) >= FullTurn) begin
			wrapped = 15'(int'(angle) - FullTurn);
		end else begin
			wrapped = 15'(angle);
		end
		if (int'(wrapped) + QuarterTurn >= FullTurn) begin
			cwrap = 15'(int'(wrapped) + QuarterTurn - FullTurn);
		end else begin
			cwrap = 15'(int'(wrapped) + QuarterTurn);
		end
	end

	function automatic logic [13:0] fold(input logic [14:0] w);
		logic [12:0] f;
		logic neg;
		begin
			if (int'(w) < QuarterTurn) begin
				f = 13'(w); neg = 1'b0;
			end else if (int'(w) < 2 * QuarterTurn) begin
				f = 13'(2 * QuarterTurn - int'(w)); neg = 1'b0;
			end else if (int'(w) < 3 * QuarterTurn) begin
				f = 13'(int'(w) - 2 * QuarterTurn); neg = 1'b1;
			end else begin
				f = 13'(FullTurn - int'(w)); neg = 1'b1;
			end
			fold = {neg, f};
		end
	endfunction

	always_comb begin
		{sn, sf} = fold(wrapped);
		{cn, cf} = fold(cwrap);
	end

	always_ff @(posedge clk) begin
		sf_s1 <= sf;
		cf_s1 <= cf;
		sn_s1 <= sn;
		cn_s1 <= cn;
	end

	always_ff @(posedge clk) begin
		smag_s2 <= sine_rom[sf_s1];
		cmag_s2 <= sine_rom[cf_s1];
		sn_s2 <= sn_s1;
		cn_s2 <= cn_s1;
	end

	always_comb begin
		sin_val = sn_s2 ? -$signed(smag_s2) : $signed(smag_s2);
		cos_val = cn_s2 ? -$signed(cmag_s2) : $signed(cmag_s2);
	end

endmodule

// ===== rtl/core/ckm_datapath.sv =====
// ----------------------------------------------------------------------------
// ckm_datapath: cluster storage, distance scan, accumulation and divider
// Means, sums and tallies live in registers; one mean is compared per step.
// ----------------------------------------------------------------------------
module ckm_datapath import ckm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ckm_cmd_t               cmd,
	input  logic [IdxW-1:0]        in_slot,
	input  logic signed [AngW-1:0] in_angle,
	input  logic [IdxW:0]          n_active,
	output ckm_status_t            status,
	output logic signed [AngW-1:0] res_mean,
	output logic [CntW-1:0]        res_count
);

	logic signed [AngW-1:0] mean_q [MaxClusters];
	logic signed [SumW-1:0] sum_q [MaxClusters];
	logic [CntW-1:0]        tally_q [MaxClusters];
	logic [PassW-1:0]       pass_q;

	logic signed [AngW-1:0]  trig_angle;
	logic signed [TrigW-1:0] t_sin, t_cos;
	logic signed [TrigW-1:0] s_sin_q, s_cos_q;
	logic [IdxW-1:0]         best_q;
	logic [DistW-1:0]        best_d_q;
	logic [IdxW:0]           scan_q;
	logic [1:0]              wait_q;
	logic signed [AngW-1:0]  samp_q;

	// scan: trig of mean scan_q goes through the registered trig unit, then is compared
	assign trig_angle = cmd.sample_trig ? in_angle : mean_q[scan_q[IdxW-1:0]];

	ckm_trig u_trig (
		.clk(clk), .angle(trig_angle), .sin_val(t_sin), .cos_val(t_cos)
	);

	logic signed [TrigW:0] dc, ds;
	logic signed [2*TrigW+1:0] pc, ps;
	logic [DistW-1:0] sq_dist;
	always_comb begin
		dc = (TrigW+1)'(s_cos_q) - (TrigW+1)'(t_cos);
		ds = (TrigW+1)'(s_sin_q) - (TrigW+1)'(t_sin);
		pc = dc * dc;
		ps = ds * ds;
		sq_dist = $unsigned(pc) + $unsigned(ps);
	end

	// Restoring divider on magnitudes, one quotient bit per cycle.
	logic [DivW-1:0]  rem_q, quo_q, dvs_q;
	logic [4:0]       dcnt_q;
	logic             neg_q, dbusy_q;
	logic [DivW:0]    trial;
	logic signed [DivW-1:0] total;
	always_comb begin
		total = DivW'(mean_q[cmd.idx]) + DivW'(sum_q[cmd.idx]);
		trial = {rem_q, quo_q[DivW-1]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxClusters; i++) begin
				mean_q[i] <= '0;
				sum_q[i] <= '0;
				tally_q[i] <= '0;
			end
			pass_q <= '0;
			scan_q <= '0;
			wait_q <= '0;
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load_mean) mean_q[in_slot] <= in_angle;
			if (cmd.sample_trig) begin
				samp_q <= in_angle;
				wait_q <= 2'd2;
			end else if (wait_q != 0) begin
				wait_q <= wait_q - 2'd1;
				if (wait_q == 2'd1) begin
					s_sin_q <= t_sin;
					s_cos_q <= t_cos;
				end
			end
			if (cmd.scan_start) scan_q <= '0;
			if (cmd.scan_step) begin
				// trig output at this edge belongs to mean scan_q - 2
				if (scan_q >= 2) begin
					if (scan_q == 2 || sq_dist < best_d_q) begin
						best_d_q <= sq_dist;
						best_q <= IdxW'(scan_q - 2);
					end
				end
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.accumulate) begin
				sum_q[best_q] <= sum_q[best_q] + SumW'(samp_q);
				tally_q[best_q] <= tally_q[best_q] + 1'b1;
				pass_q <= pass_q + 1'b1;
			end
			if (cmd.div_start) begin
				neg_q <= total[DivW-1];
				rem_q <= '0;
				quo_q <= total[DivW-1] ? -total : total;
				dvs_q <= DivW'(tally_q[cmd.idx]) + 1'b1;
				dcnt_q <= 5'(DivW);
				dbusy_q <= tally_q[cmd.idx] != 0;
			end else if (dbusy_q) begin
				if (!trial[DivW]) begin
					rem_q <= trial[DivW-1:0];
					quo_q <= {quo_q[DivW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
					quo_q <= {quo_q[DivW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == 5'd1) begin
					dbusy_q <= 1'b0;
					mean_q[cmd.idx] <= neg_q ? -AngW'(trial[DivW] ? {quo_q[DivW-2:0], 1'b0}
					                                            : {quo_q[DivW-2:0], 1'b1})
					                         : AngW'(trial[DivW] ? {quo_q[DivW-2:0], 1'b0}
					                                             : {quo_q[DivW-2:0], 1'b1});
				end
			end
			if (cmd.emit_clear) begin
				for (int i = 0; i < MaxClusters; i++) begin
					sum_q[i] <= '0;
					tally_q[i] <= '0;
				end
				pass_q <= '0;
			end
		end
	end

	assign status.scan_done = cmd.scan_step && (scan_q == n_active + 1);
	assign status.div_done = !dbusy_q;
	assign status.pass_full = pass_q >= PassW'(MaxSamples);
	assign res_mean = mean_q[cmd.idx];
	assign res_count = tally_q[cmd.idx];

endmodule

// ===== rtl/core/ckm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckm_ctrl: sequencer for load, sample scan and end-of-pass update
// Steps the datapath through trig, scan, accumulate, divide and emit.
// ----------------------------------------------------------------------------
module ckm_ctrl import ckm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_kind,
	input  logic            in_last,
	input  logic [IdxW:0]   n_active,
	input  ckm_status_t     status,
	output ckm_cmd_t        cmd,
	output logic            out_load,
	input  logic            out_free
);

	ckm_state_t state_q, state_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic last_q, last_d;
	logic [1:0] tw_q, tw_d;
	logic started_q, started_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			last_q <= 1'b0;
			tw_q <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			last_q <= last_d;
			tw_q <= tw_d;
			started_q <= started_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		last_d = last_q;
		tw_d = tw_q;
		started_d = started_q;
		cmd = '0;
		cmd.idx = idx_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_kind) begin
						cmd.load_mean = 1'b1;
					end else if (status.pass_full) begin
						if (in_last) begin
							idx_d = '0;
							started_d = 1'b0;
							state_d = ST_DIVIDE;
						end
					end else begin
						cmd.sample_trig = 1'b1;
						last_d = in_last;
						tw_d = 2'd2;
						state_d = ST_SAMPLE_TRIG;
					end
				end
			end
			ST_SAMPLE_TRIG: begin
				tw_d = tw_q - 2'd1;
				if (tw_q == 2'd1) begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accumulate = 1'b1;
				idx_d = '0;
				started_d = 1'b0;
				state_d = last_q ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (!started_q) begin
					cmd.div_start = 1'b1;
					started_d = 1'b1;
				end else if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					started_d = 1'b0;
					if ({1'b0, idx_q} == n_active - 1'b1) begin
						cmd.emit_clear = 1'b1;
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = ST_DIVIDE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== bench/circular_kmeans_iteration_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_kmeans_iteration_checker: prediction and comparison
// Watches the input and output channels and the register write port. It
// keeps its own copy of the cluster means, sums and tallies, predicts the
// result words of every pass and compares them with the words sent.
// ----------------------------------------------------------------------------
module circular_kmeans_iteration_checker import ckm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   kind,
	input  logic [IdxW-1:0]        cluster_slot,
	input  logic signed [AngW-1:0] angle,
	input  logic                   last_sample,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [IdxW-1:0]        cluster_index,
	input  logic signed [AngW-1:0] new_mean,
	input  logic [CntW-1:0]        member_count,
	input  logic                   last_result,
	output int                     fail_count,
	output int                     pending_results
);

	typedef struct packed {
		logic [IdxW-1:0]        idx;
		logic signed [AngW-1:0] mean;
		logic [CntW-1:0]        cnt;
		logic                   last;
	} cluster_result_t;

	localparam int KindLoad = 0;

	cluster_result_t expected_results[$];
	logic [3:0] count_reg;
	longint means[MaxClusters];
	longint sums[MaxClusters];
	int tallies[MaxClusters];
	int samples_in_pass;

	assign pending_results = expected_results.size();

	// Quarter-wave sine of the angle folded into 0..5760, Q1.14.
	function automatic longint sine_quarter(longint f);
		longint unsigned r, r2, t, s, one;
		one = 64'd1 << 30;
		r = f * 64'd292818;
		r2 = (r * r) >> 30;
		t = one - r2 / 72;
		t = one - ((r2 * t) >> 30) / 42;
		t = one - ((r2 * t) >> 30) / 20;
		t = one - ((r2 * t) >> 30) / 6;
		s = (r * t) >> 30;
		return longint'((s + 64'd32768) >> 16);
	endfunction

	function automatic longint sine_of(longint a);
		longint w, f;
		w = a % FullTurn;
		if (w < 0) w += FullTurn;
		f = w % QuarterTurn;
		case (w / QuarterTurn)
			0: return sine_quarter(f);
			1: return sine_quarter(QuarterTurn - f);
			2: return -sine_quarter(f);
			default: return -sine_quarter(QuarterTurn - f);
		endcase
	endfunction

	function automatic int clusters_in_use();
		if (count_reg == 0) return 1;
		if (count_reg > MaxClusters) return MaxClusters;
		return int'(count_reg);
	endfunction

	task automatic absorb_word(logic k, logic [IdxW-1:0] slot, logic signed [AngW-1:0] a,
			logic lst);
		int n, best;
		longint cs, ss, dc, ds, d, best_d;
		cluster_result_t res;
		n = clusters_in_use();
		if (k == KindLoad) begin
			means[slot] = a;
			return;
		end
		if (samples_in_pass < MaxSamples) begin
			cs = sine_of(longint'(a) + QuarterTurn);
			ss = sine_of(a);
			best = 0;
			best_d = 0;
			for (int i = 0; i < n; i++) begin
				dc = cs - sine_of(means[i] + QuarterTurn);
				ds = ss - sine_of(means[i]);
				d = dc * dc + ds * ds;
				if (i == 0 || d < best_d) begin
					best_d = d;
					best = i;
				end
			end
			sums[best] += a;
			tallies[best]++;
			samples_in_pass++;
		end
		if (!lst) return;
		for (int i = 0; i < n; i++) begin
			if (tallies[i] != 0) means[i] = (means[i] + sums[i]) / (tallies[i] + 1);
			res.idx = i[IdxW-1:0];
			res.mean = means[i][AngW-1:0];
			res.cnt = tallies[i][CntW-1:0];
			res.last = (i + 1 == n);
			expected_results.push_back(res);
		end
		for (int i = 0; i < MaxClusters; i++) begin
			sums[i] = 0;
			tallies[i] = 0;
		end
		samples_in_pass = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cluster_result_t want;
		if (!arst_n) begin
			count_reg = 4'd2;
			for (int i = 0; i < MaxClusters; i++) begin
				means[i] = 0;
				sums[i] = 0;
				tallies[i] = 0;
			end
			samples_in_pass = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with none expected: idx %0d", cluster_index);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (cluster_index !== want.idx) begin
						$error("cluster_index exp %0d got %0d", want.idx, cluster_index);
						fail_count++;
					end
					if (new_mean !== want.mean) begin
						$error("new_mean exp %0d got %0d", want.mean, new_mean);
						fail_count++;
					end
					if (member_count !== want.cnt) begin
						$error("member_count exp %0d got %0d", want.cnt, member_count);
						fail_count++;
					end
					if (last_result !== want.last) begin
						$error("last_result exp %0d got %0d", want.last, last_result);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) absorb_word(kind, cluster_slot, angle, last_sample);
			if (cfg_we) count_reg = cfg_data;
		end
	end

endmodule

// ===== bench/circular_kmeans_iteration_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_kmeans_iteration_tb: top level of the k-means pass testbench
// Drives load and sample words with random gaps and output stalls, changes
// the cluster count between passes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module circular_kmeans_iteration_tb;
	import ckm_pkg::*;

	localparam logic KindLoad = 1'b0;
	localparam logic KindSample = 1'b1;
	// The drain margin covers the division of a pass of eight clusters.
	localparam int DrainCycles = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [IdxW-1:0] cluster_slot = '0;
	logic signed [AngW-1:0] angle = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IdxW-1:0] cluster_index;
	logic signed [AngW-1:0] new_mean;
	logic [CntW-1:0] member_count;
	logic last_result;
	int fail_count;
	int pending_results;
	// While set, neither side inserts idle cycles.
	logic steady = 1'b0;

	always #1 clk = ~clk;

	circular_kmeans_iteration dut (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .kind, .cluster_slot,
		.angle, .last_sample, .out_valid, .out_ready, .cluster_index, .new_mean,
		.member_count, .last_result
	);

	circular_kmeans_iteration_checker checker_i (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .kind, .cluster_slot,
		.angle, .last_sample, .out_valid, .out_ready, .cluster_index, .new_mean,
		.member_count, .last_result, .fail_count, .pending_results
	);

	// The receiver stalls about 37 percent of the time, except in the steady stretch.
	always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 37);

	// Offers one word and holds it until the block takes it. A random gap
	// precedes the word unless the steady stretch is on; without a gap the
	// next word follows straight after the previous one is taken.
	task automatic send_word(logic k, logic [IdxW-1:0] slot, logic signed [AngW-1:0] a,
			logic lst);
		while (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		cluster_slot <= slot;
		angle <= a;
		last_sample <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	// Waits for every expected word, then lets the block settle before a write.
	task automatic drain_pass();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_count(logic [3:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Most random angles lie in range; a few wrap past the half circle.
	function automatic logic signed [AngW-1:0] random_angle();
		if ($urandom_range(9) == 0) return AngW'($urandom);
		return AngW'($signed($urandom_range(23040)) - 11520);
	endfunction

	task automatic random_pass(int samples);
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) send_word(KindLoad, i[IdxW-1:0], random_angle(), 1'b0);
		for (int i = 0; i < samples; i++) begin
			// An occasional mean reload, with a random last mark that must be ignored.
			if ($urandom_range(19) == 0)
				send_word(KindLoad, 3'($urandom), random_angle(), 1'($urandom));
			send_word(KindSample, 3'($urandom), random_angle(), i == samples - 1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset count of two: extreme angles, ties at zero.
		send_word(KindSample, 3'd0, 15'sd0, 1'b0);
		send_word(KindLoad, 3'd1, 15'sd11520, 1'b1);
		send_word(KindSample, 3'd7, -15'sd11520, 1'b0);
		send_word(KindSample, 3'd0, 15'sd11520, 1'b0);
		send_word(KindSample, 3'd0, 15'sh3fff, 1'b0);
		send_word(KindSample, 3'd0, 15'sh4000, 1'b0);
		send_word(KindSample, 3'd0, 15'sd5760, 1'b1);
		drain_pass();

		// A zero count behaves as one cluster.
		write_count(4'd0);
		send_word(KindSample, 3'd0, -15'sd5760, 1'b0);
		send_word(KindSample, 3'd0, 15'sd100, 1'b1);
		drain_pass();

		// Counts above eight are clipped; loads into every slot.
		write_count(4'd15);
		for (int i = 0; i < 8; i++)
			send_word(KindLoad, i[IdxW-1:0], AngW'((i - 4) * 2880), 1'b0);
		send_word(KindSample, 3'd0, 15'sd1440, 1'b0);
		send_word(KindSample, 3'd0, 15'sd1440, 1'b0);
		send_word(KindSample, 3'd0, -15'sd10000, 1'b1);
		drain_pass();

		// Random passes at random counts from 1 to 15, ending at eight; one runs with no idling.
		for (int p = 0; p < 9; p++) begin
			write_count(p == 8 ? 4'd8 : 4'($urandom_range(1, 15)));
			steady <= (p == 2);
			random_pass(p == 2 ? 16 : $urandom_range(3, 16));
			steady <= 1'b0;
			drain_pass();
		end
		write_count(4'd1);
		random_pass(6);
		drain_pass();

		if (fail_count == 0)
			$display("circular_kmeans_iteration_tb OK");
		else
			$display("circular_kmeans_iteration_tb NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("circular_kmeans_iteration_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ckm_pkg.sv
rtl/core/ckm_trig.sv
rtl/core/ckm_datapath.sv
rtl/core/ckm_ctrl.sv
rtl/core/circular_kmeans_iteration.sv
bench/circular_kmeans_iteration_checker.sv
bench/circular_kmeans_iteration_tb.sv
